// ===== sv/vat_pkg.sv =====
`default_nettype none

package vat_pkg;

    localparam int COORD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 14;
    localparam int SCALE_FRAC = 8;
    localparam int COORD_FRAC = 16;
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int WIDE_W     = PROD_W + 1;
    localparam int ROW_W      = PROD_W + 2;
    localparam int ROT_W      = ROW_W - COEF_FRAC;
    localparam int MAG_W      = 30;
    localparam int MSB_W      = 6;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int LEN_W      = SUM_W / 2;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int QUO_W      = COORD_FRAC + 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int REM_W      = MAG_W + COORD_FRAC + 2;
    localparam int REG_W      = 3 * COEF_W;
    localparam int PADDR_W    = 6;
    localparam int PDATA_W    = 64;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ROT_W-1:0]   rot_t;
    typedef logic [ROT_W-1:0]          rmag_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [QUO_W-1:0]          quo_t;

    typedef enum logic [2:0] {
        REG_ROT_ROW0,
        REG_ROT_ROW1,
        REG_ROT_ROW2,
        REG_SCALE_XYZ,
        REG_SHIFT_X,
        REG_SHIFT_Y,
        REG_SHIFT_Z
    } reg_idx_t;

    // Sideband that rides along the normalize pipeline.
    typedef struct packed {
        logic               func;
        logic               zero;
        logic [2:0]         neg;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
    } side_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               zero;
    } res_t;

    function automatic logic [MSB_W-1:0] lead_one(input logic [ROT_W-1:0] v);
        logic [MSB_W-1:0] r;
        r = '0;
        for (int i = 0; i < ROT_W; i++) begin
            if (v[i]) begin
                r = MSB_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
        if ((&v[WIDE_W-1:COORD_W-1]) || !(|v[WIDE_W-1:COORD_W-1])) begin
            return v[COORD_W-1:0];
        end
        return v[WIDE_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

// ===== sv/vat_norm.sv =====
`default_nettype none

module vat_norm (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire vat_pkg::mag_t [2:0]    in_mag,
    input  wire vat_pkg::side_t         in_side,
    output logic                        out_valid,
    output vat_pkg::quo_t [2:0]         out_quo,
    output vat_pkg::side_t              out_side
);
    import vat_pkg::*;

    // squares
    logic              sq_valid_reg;
    logic [SQ_W-1:0]   sq_reg [3];
    mag_t [2:0]        sq_mag_reg;
    side_t             sq_side_reg;

    // square root: index 0 holds the sum of squares
    logic [SQRT_STEPS:0] rt_valid_reg;
    logic [SUM_W-1:0]    rt_x_reg    [SQRT_STEPS+1];
    logic [SUM_W-1:0]    rt_res_reg  [SQRT_STEPS+1];
    mag_t [2:0]          rt_mag_reg  [SQRT_STEPS+1];
    side_t               rt_side_reg [SQRT_STEPS+1];

    // division: index 0 holds the rounded numerators
    logic [DIV_STEPS:0]     dv_valid_reg;
    logic [2:0][REM_W-1:0]  dv_rem_reg  [DIV_STEPS+1];
    quo_t [2:0]             dv_q_reg    [DIV_STEPS+1];
    logic [LEN_W-1:0]       dv_len_reg  [DIV_STEPS+1];
    side_t                  dv_side_reg [DIV_STEPS+1];

    logic [LEN_W-1:0] len;

    assign len = rt_res_reg[SQRT_STEPS][LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg    <= 1'b0;
            rt_valid_reg[0] <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            sq_valid_reg    <= in_valid;
            rt_valid_reg[0] <= sq_valid_reg;
            dv_valid_reg[0] <= rt_valid_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SQ_W'(in_mag[i]) * SQ_W'(in_mag[i]);
            end
            sq_mag_reg  <= in_mag;
            sq_side_reg <= in_side;

            rt_x_reg[0]    <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            rt_res_reg[0]  <= '0;
            rt_mag_reg[0]  <= sq_mag_reg;
            rt_side_reg[0] <= sq_side_reg;

            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= REM_W'({rt_mag_reg[SQRT_STEPS][i], {COORD_FRAC{1'b0}}})
                                    + REM_W'(len >> 1);
            end
            dv_q_reg[0]    <= '0;
            dv_len_reg[0]  <= len;
            dv_side_reg[0] <= rt_side_reg[SQRT_STEPS];
        end
    end

    // One result bit of the square root per stage.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam int SH = SUM_W - 2 - 2 * k;
        logic [SUM_W-1:0] rbit;
        logic [SUM_W-1:0] trial;

        assign rbit  = SUM_W'(1) << SH;
        assign trial = rt_res_reg[k] + rbit;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                rt_valid_reg[k+1] <= rt_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rt_x_reg[k] >= trial) begin
                    rt_x_reg[k+1]   <= rt_x_reg[k] - trial;
                    rt_res_reg[k+1] <= (rt_res_reg[k] >> 1) + rbit;
                end else begin
                    rt_x_reg[k+1]   <= rt_x_reg[k];
                    rt_res_reg[k+1] <= rt_res_reg[k] >> 1;
                end
                rt_mag_reg[k+1]  <= rt_mag_reg[k];
                rt_side_reg[k+1] <= rt_side_reg[k];
            end
        end
    end

    // Restoring division, one quotient bit per stage on all three lanes.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - j;
        logic [REM_W-1:0] dsr;

        assign dsr = REM_W'(dv_len_reg[j]) << SH;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (dv_rem_reg[j][i] >= dsr) begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i] - dsr;
                        dv_q_reg[j+1][i]   <= {dv_q_reg[j][i][QUO_W-2:0], 1'b1};
                    end else begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i];
                        dv_q_reg[j+1][i]   <= {dv_q_reg[j][i][QUO_W-2:0], 1'b0};
                    end
                end
                dv_len_reg[j+1]  <= dv_len_reg[j];
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    assign out_valid = dv_valid_reg[DIV_STEPS];
    assign out_quo   = dv_q_reg[DIV_STEPS];
    assign out_side  = dv_side_reg[DIV_STEPS];

endmodule

`default_nettype wire

// ===== sv/vertex_affine_transform_core.sv =====
// Vertex affine transform core.
// Input channel (s_valid/s_ready): one vector per transaction, s_func selects
// position (0) or normal (1); coordinates are signed Q16.16.
// Position: out = R * (v * scale) + shift, saturated. Normal: out = R * v,
// normalized to unit length; a normal that rotates to zero returns zeros
// with m_zero_length set.
// Result channel (m_valid/m_ready): one transaction per input transaction,
// in order.
// Configuration: APB-style port, 64-bit data, register i at byte 8*i
// (rotation rows, scale, shift x/y/z). Write only while the core is idle.
// The integer square root (31 stages) and the three-lane divider set the
// pipeline depth; every item, position or normal, takes the same path.
// Throughput: one transaction per cycle while the pipeline is not stalled.
// Reset: synchronous, active low; empties the pipeline and loads the
// identity rotation, unit scale and zero shift.
// Stall: the whole pipeline holds while the output skid register is full.
// One result may wait in the output register and one in the skid register,
// so s_ready falls in the cycle after a further result reaches a stalled output.
`default_nettype none

module vertex_affine_transform_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_func,
    input  wire logic signed [31:0]            s_in_x,
    input  wire logic signed [31:0]            s_in_y,
    input  wire logic signed [31:0]            s_in_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [31:0]                 m_out_x,
    output logic signed [31:0]                 m_out_y,
    output logic signed [31:0]                 m_out_z,
    output logic                               m_zero_length,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vat_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [vat_pkg::PDATA_W-1:0]   pwdata,
    output logic [vat_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import vat_pkg::*;

    localparam logic signed [WIDE_W-1:0] SCALE_HALF = WIDE_W'(1) << (SCALE_FRAC - 1);
    localparam logic signed [ROW_W-1:0]  ROW_HALF   = ROW_W'(1) << (COEF_FRAC - 1);
    localparam logic [MSB_W-1:0]         NORM_MSB   = MSB_W'(MAG_W - 1);

    // ---------------- configuration registers ----------------
    logic [REG_W-1:0] rot_row_reg [3];
    logic [REG_W-1:0] scale_reg;
    coord_t           shift_reg [3];
    reg_idx_t         cfg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_row_reg[0] <= REG_W'(1) << COEF_FRAC;
            rot_row_reg[1] <= REG_W'(1) << (COEF_FRAC + COEF_W);
            rot_row_reg[2] <= REG_W'(1) << (COEF_FRAC + 2 * COEF_W);
            scale_reg      <= {3{COEF_W'(1) << SCALE_FRAC}};
            shift_reg[0]   <= '0;
            shift_reg[1]   <= '0;
            shift_reg[2]   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ROT_ROW0:  rot_row_reg[0] <= pwdata[REG_W-1:0];
                REG_ROT_ROW1:  rot_row_reg[1] <= pwdata[REG_W-1:0];
                REG_ROT_ROW2:  rot_row_reg[2] <= pwdata[REG_W-1:0];
                REG_SCALE_XYZ: scale_reg      <= pwdata[REG_W-1:0];
                REG_SHIFT_X:   shift_reg[0]   <= pwdata[COORD_W-1:0];
                REG_SHIFT_Y:   shift_reg[1]   <= pwdata[COORD_W-1:0];
                REG_SHIFT_Z:   shift_reg[2]   <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ROT_ROW0:  prdata = PDATA_W'(rot_row_reg[0]);
            REG_ROT_ROW1:  prdata = PDATA_W'(rot_row_reg[1]);
            REG_ROT_ROW2:  prdata = PDATA_W'(rot_row_reg[2]);
            REG_SCALE_XYZ: prdata = PDATA_W'(scale_reg);
            REG_SHIFT_X:   prdata = PDATA_W'(unsigned'(shift_reg[0]));
            REG_SHIFT_Y:   prdata = PDATA_W'(unsigned'(shift_reg[1]));
            REG_SHIFT_Z:   prdata = PDATA_W'(unsigned'(shift_reg[2]));
            default:       prdata = '0;
        endcase
    end

    // Unpack coefficients and scales.
    logic signed [COEF_W-1:0] coef [3][3];
    logic signed [COEF_W-1:0] scl  [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r][c] = rot_row_reg[r][COEF_W*c +: COEF_W];
            end
            scl[r] = scale_reg[COEF_W*r +: COEF_W];
        end
    end

    // ---------------- pipeline control ----------------
    // The whole pipeline advances together; it holds only when the skid
    // register is occupied.
    logic skid_full_reg, skid_full_next;
    logic out_valid_reg, out_valid_next;
    logic pipe_en;

    assign pipe_en = !skid_full_reg;
    assign s_ready = pipe_en;

    // Stage 1: capture input.
    logic   s1_valid_reg, s1_func_reg;
    coord_t s1_v_reg [3];
    // Stage 2: scale products.
    logic   s2_valid_reg, s2_func_reg;
    coord_t s2_v_reg [3];
    prod_t  s2_prod_reg [3];
    // Stage 3: rounded, saturated scale or raw normal.
    logic   s3_valid_reg, s3_func_reg;
    coord_t s3_src_reg [3];
    // Stage 4: nine rotation products.
    logic   s4_valid_reg, s4_func_reg;
    prod_t  s4_prod_reg [3][3];
    // Stage 5: rounded row sums.
    logic   s5_valid_reg, s5_func_reg;
    rot_t   s5_rot_reg [3];
    // Stage 6: translated position, normal magnitudes.
    logic         s6_valid_reg, s6_func_reg;
    logic [2:0]   s6_neg_reg;
    rmag_t        s6_mag_reg [3];
    coord_t       s6_pos_reg [3];
    // Stage 7: leading-one position of the largest magnitude.
    logic             s7_valid_reg, s7_func_reg, s7_zero_reg;
    logic [2:0]       s7_neg_reg;
    rmag_t            s7_mag_reg [3];
    coord_t           s7_pos_reg [3];
    logic [MSB_W-1:0] s7_msb_reg;
    // Stage 8: magnitudes aligned so the largest has its top bit at MAG_W-1.
    logic       s8_valid_reg;
    mag_t [2:0] s8_mag_reg;
    side_t      s8_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    logic signed [WIDE_W-1:0] scl_rnd [3];
    logic signed [ROW_W-1:0]  row_sum [3];
    logic signed [WIDE_W-1:0] pos_sum [3];
    logic [ROT_W-1:0]         mag_or;
    logic [ROT_W-1:0]         mag_aln [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            scl_rnd[i] = (WIDE_W'(s2_prod_reg[i]) + SCALE_HALF) >>> SCALE_FRAC;
            row_sum[i] = ROW_W'(s4_prod_reg[i][0]) + ROW_W'(s4_prod_reg[i][1])
                         + ROW_W'(s4_prod_reg[i][2]) + ROW_HALF;
            pos_sum[i] = WIDE_W'(s5_rot_reg[i]) + WIDE_W'(shift_reg[i]);
            // Truncate on a right shift, exact on a left shift.
            if (s7_msb_reg > NORM_MSB) begin
                mag_aln[i] = s7_mag_reg[i] >> (s7_msb_reg - NORM_MSB);
            end else begin
                mag_aln[i] = s7_mag_reg[i] << (NORM_MSB - s7_msb_reg);
            end
        end
        mag_or = s6_mag_reg[0] | s6_mag_reg[1] | s6_mag_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_func_reg <= s_func;
            s1_v_reg[0] <= s_in_x;
            s1_v_reg[1] <= s_in_y;
            s1_v_reg[2] <= s_in_z;

            s2_func_reg <= s1_func_reg;
            s3_func_reg <= s2_func_reg;
            s4_func_reg <= s3_func_reg;
            s5_func_reg <= s4_func_reg;
            s6_func_reg <= s5_func_reg;
            s7_func_reg <= s6_func_reg;

            for (int i = 0; i < 3; i++) begin
                s2_v_reg[i]    <= s1_v_reg[i];
                s2_prod_reg[i] <= PROD_W'(s1_v_reg[i]) * PROD_W'(scl[i]);

                // Normals skip scale.
                s3_src_reg[i] <= s2_func_reg ? s2_v_reg[i] : sat_coord(scl_rnd[i]);

                for (int c = 0; c < 3; c++) begin
                    s4_prod_reg[i][c] <= PROD_W'(coef[i][c]) * PROD_W'(s3_src_reg[c]);
                end

                s5_rot_reg[i] <= row_sum[i][ROW_W-1:COEF_FRAC];

                s6_pos_reg[i] <= sat_coord(pos_sum[i]);
                s6_neg_reg[i] <= s5_rot_reg[i][ROT_W-1];
                s6_mag_reg[i] <= s5_rot_reg[i][ROT_W-1] ? rmag_t'(-s5_rot_reg[i])
                                                        : rmag_t'(s5_rot_reg[i]);

                s7_mag_reg[i] <= s6_mag_reg[i];
                s7_pos_reg[i] <= s6_pos_reg[i];

                s8_mag_reg[i] <= mag_aln[i][MAG_W-1:0];
            end

            s7_neg_reg  <= s6_neg_reg;
            s7_msb_reg  <= lead_one(mag_or);
            s7_zero_reg <= (mag_or == '0);

            s8_side_reg.func  <= s7_func_reg;
            s8_side_reg.zero  <= s7_zero_reg;
            s8_side_reg.neg   <= s7_neg_reg;
            s8_side_reg.pos_x <= s7_pos_reg[0];
            s8_side_reg.pos_y <= s7_pos_reg[1];
            s8_side_reg.pos_z <= s7_pos_reg[2];
        end
    end

    // ---------------- square root and divide ----------------
    logic       n_valid;
    quo_t [2:0] n_quo;
    side_t      n_side;

    vat_norm u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_valid (s8_valid_reg),
        .in_mag   (s8_mag_reg),
        .in_side  (s8_side_reg),
        .out_valid(n_valid),
        .out_quo  (n_quo),
        .out_side (n_side)
    );

    // Pick the final components.
    logic [COORD_W-1:0] q_ext [3];
    logic [COORD_W-1:0] n_comp [3];
    res_t               res_new;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_ext[i] = COORD_W'(n_quo[i]);
            if (n_side.zero) begin
                n_comp[i] = '0;
            end else begin
                n_comp[i] = n_side.neg[i] ? -q_ext[i] : q_ext[i];
            end
        end
        res_new.x    = n_side.func ? n_comp[0] : n_side.pos_x;
        res_new.y    = n_side.func ? n_comp[1] : n_side.pos_y;
        res_new.z    = n_side.func ? n_comp[2] : n_side.pos_z;
        res_new.zero = n_side.func && n_side.zero;
    end

    // ---------------- output register and skid ----------------
    res_t out_reg, skid_reg;
    logic load_out, load_skid, from_skid;

    always_comb begin
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        load_out       = 1'b0;
        load_skid      = 1'b0;
        from_skid      = 1'b0;
        if (skid_full_reg) begin
            // Pipeline holds; drain skid into the output when taken.
            if (m_ready) begin
                from_skid      = 1'b1;
                skid_full_next = 1'b0;
            end
        end else if (n_valid) begin
            if (!out_valid_reg || m_ready) begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end else begin
                load_skid      = 1'b1;
                skid_full_next = 1'b1;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= res_new;
        end else if (from_skid) begin
            out_reg <= skid_reg;
        end
        if (load_skid) begin
            skid_reg <= res_new;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_x       = out_reg.x;
    assign m_out_y       = out_reg.y;
    assign m_out_z       = out_reg.z;
    assign m_zero_length = out_reg.zero;

endmodule

`default_nettype wire

// ===== sv/vat_checker.sv =====
`default_nettype none

module vat_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic signed [31:0]            m_out_x,
    input wire logic signed [31:0]            m_out_y,
    input wire logic signed [31:0]            m_out_z,
    input wire logic                          m_zero_length
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_x) && $stable(m_out_y)
                                && $stable(m_out_z) && $stable(m_zero_length))
        else $error("stalled result changed");

    // A zero-length normal reports zeros.
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_length |-> m_out_x == 0 && m_out_y == 0 && m_out_z == 0)
        else $error("zero-length normal with nonzero output");

    // Input backpressure only comes from a stalled, full output.
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input blocked with no result pending");

    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input blocked without an output stall");

endmodule

bind vertex_affine_transform_core vat_checker u_vat_checker (.*);

`default_nettype wire
